>>> rtl/time_ordered_event_queue_core_macros.svh
// Assertion macros shared by the event queue modules.
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_MACROS_SVH

// Checks on every clock edge outside reset that the antecedent implies the consequent.
`define TOEQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds on every clock edge outside reset.
`define TOEQ_ASSERT_ALWAYS(label, cond, msg) \
   `TOEQ_ASSERT_IMPLY(label, 1'b1, cond, msg)

`endif

>>> rtl/toeq_pkg.sv
`default_nettype none

package toeq_pkg;

   localparam int DEPTH         = 16;
   localparam int COUNT_WIDTH   = $clog2(DEPTH + 1);
   localparam int MODE_WIDTH    = 2;
   localparam int TIME_WIDTH    = 32;
   localparam int HANDLER_WIDTH = 8;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int KIND_WIDTH    = 3;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_ADD   = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_ADDED    = 3'd0,
      KIND_DROPPED  = 3'd1,
      KIND_FIRED    = 3'd2,
      KIND_NONE_DUE = 3'd3,
      KIND_CLEARED  = 3'd4
   } kind_type;

   typedef struct packed {
      logic     latch_req;
      logic     do_insert;
      logic     do_pop;
      logic     do_clear;
      logic     load_out;
      kind_type out_kind;
      logic     out_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_due;
      logic next_due;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/toeq_req_if.sv
`default_nettype none

interface toeq_req_if;
   import toeq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MODE_WIDTH-1:0]    mode;
   logic [TIME_WIDTH-1:0]    due_time;
   logic [HANDLER_WIDTH-1:0] handler_id;
   logic [PAYLOAD_WIDTH-1:0] payload;
   logic [TIME_WIDTH-1:0]    now;

   modport source (output valid, mode, due_time, handler_id, payload, now, input ready);
   modport sink (input valid, mode, due_time, handler_id, payload, now, output ready);

endinterface

`default_nettype wire

>>> rtl/toeq_rsp_if.sv
`default_nettype none

interface toeq_rsp_if;
   import toeq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_WIDTH-1:0]    kind;
   logic [HANDLER_WIDTH-1:0] fired_handler;
   logic [PAYLOAD_WIDTH-1:0] fired_payload;
   logic [TIME_WIDTH-1:0]    fired_time;
   logic                     last;

   modport source (output valid, kind, fired_handler, fired_payload, fired_time, last,
                   input ready);
   modport sink (input valid, kind, fired_handler, fired_payload, fired_time, last,
                 output ready);

endinterface

`default_nettype wire

>>> rtl/toeq_dp.sv
`default_nettype none
`include "time_ordered_event_queue_core_macros.svh"

module toeq_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire toeq_pkg::cmd_type                 cmd,
   output toeq_pkg::status_type                   status,
   input  wire logic [toeq_pkg::TIME_WIDTH-1:0]    req_due_time,
   input  wire logic [toeq_pkg::HANDLER_WIDTH-1:0] req_handler_id,
   input  wire logic [toeq_pkg::PAYLOAD_WIDTH-1:0] req_payload,
   input  wire logic [toeq_pkg::TIME_WIDTH-1:0]    req_now,
   output logic [toeq_pkg::KIND_WIDTH-1:0]         rsp_kind,
   output logic [toeq_pkg::HANDLER_WIDTH-1:0]      rsp_fired_handler,
   output logic [toeq_pkg::PAYLOAD_WIDTH-1:0]      rsp_fired_payload,
   output logic [toeq_pkg::TIME_WIDTH-1:0]         rsp_fired_time,
   output logic                                   rsp_last
);
   import toeq_pkg::*;

   logic [TIME_WIDTH-1:0]    time_ff    [DEPTH];
   logic [TIME_WIDTH-1:0]    time_in    [DEPTH];
   logic [HANDLER_WIDTH-1:0] handler_ff [DEPTH];
   logic [HANDLER_WIDTH-1:0] handler_in [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] payload_ff [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] payload_in [DEPTH];
   logic [DEPTH-1:0]         take;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [COUNT_WIDTH-1:0]   count_in;

   logic [TIME_WIDTH-1:0]    req_time_ff;
   logic [HANDLER_WIDTH-1:0] req_handler_ff;
   logic [PAYLOAD_WIDTH-1:0] req_payload_ff;
   logic [TIME_WIDTH-1:0]    req_now_ff;

   kind_type                 out_kind_ff;
   logic [HANDLER_WIDTH-1:0] out_handler_ff;
   logic [PAYLOAD_WIDTH-1:0] out_payload_ff;
   logic [TIME_WIDTH-1:0]    out_time_ff;
   logic                     out_last_ff;
   logic                     next_due;

   // A cell takes part in an insert when it is empty or holds a later time.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         take[i] = (COUNT_WIDTH'(i) >= count_ff) || (time_ff[i] > req_time_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         time_in[i]    = time_ff[i];
         handler_in[i] = handler_ff[i];
         payload_in[i] = payload_ff[i];
      end
      if (cmd.do_insert) begin
         if (take[0]) begin
            time_in[0]    = req_time_ff;
            handler_in[0] = req_handler_ff;
            payload_in[0] = req_payload_ff;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (take[i] && take[i-1]) begin
               time_in[i]    = time_ff[i-1];
               handler_in[i] = handler_ff[i-1];
               payload_in[i] = payload_ff[i-1];
            end else if (take[i]) begin
               time_in[i]    = req_time_ff;
               handler_in[i] = req_handler_ff;
               payload_in[i] = req_payload_ff;
            end
         end
      end else if (cmd.do_pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            time_in[i]    = time_ff[i+1];
            handler_in[i] = handler_ff[i+1];
            payload_in[i] = payload_ff[i+1];
         end
      end
   end

   always_comb begin
      priority if (cmd.do_clear) begin
         count_in = '0;
      end else if (cmd.do_insert) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.do_pop) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end else begin
         count_in = count_ff;
      end
   end

   generate
      if (DEPTH > 1) begin : g_next
         assign next_due = (count_ff > COUNT_WIDTH'(1)) && (time_ff[1] <= req_now_ff);
      end else begin : g_single
         assign next_due = 1'b0;
      end
   endgenerate

   assign status.full     = (count_ff == COUNT_WIDTH'(DEPTH));
   assign status.head_due = (count_ff != '0) && (time_ff[0] <= req_now_ff);
   assign status.next_due = next_due;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         time_ff[i]    <= time_in[i];
         handler_ff[i] <= handler_in[i];
         payload_ff[i] <= payload_in[i];
      end
      if (cmd.latch_req) begin
         req_time_ff    <= req_due_time;
         req_handler_ff <= req_handler_id;
         req_payload_ff <= req_payload;
         req_now_ff     <= req_now;
      end
      if (cmd.load_out) begin
         out_kind_ff <= cmd.out_kind;
         out_last_ff <= cmd.out_last;
         if (cmd.out_kind == KIND_FIRED) begin
            out_handler_ff <= handler_ff[0];
            out_payload_ff <= payload_ff[0];
            out_time_ff    <= time_ff[0];
         end else begin
            out_handler_ff <= '0;
            out_payload_ff <= '0;
            out_time_ff    <= '0;
         end
      end
   end

   assign rsp_kind          = out_kind_ff;
   assign rsp_fired_handler = out_handler_ff;
   assign rsp_fired_payload = out_payload_ff;
   assign rsp_fired_time    = out_time_ff;
   assign rsp_last          = out_last_ff;

   `TOEQ_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_WIDTH'(DEPTH), "Entry count exceeds depth.")
   `TOEQ_ASSERT_IMPLY(a_pop_nonempty, cmd.do_pop, count_ff != '0, "Pop from an empty queue.")
   `TOEQ_ASSERT_IMPLY(a_fired_due, cmd.load_out && cmd.out_kind == KIND_FIRED,
                      status.head_due, "Fired an event that is not due.")

endmodule

`default_nettype wire

>>> rtl/toeq_ctrl.sv
`default_nettype none
`include "time_ordered_event_queue_core_macros.svh"

module toeq_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [toeq_pkg::MODE_WIDTH-1:0] req_mode,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire toeq_pkg::status_type            status,
   output toeq_pkg::cmd_type                   cmd
);
   import toeq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_TICK,
      ST_CLEAR
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.out_kind = KIND_ADDED;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               unique case (mode_type'(req_mode))
                  MODE_ADD:   state_in = ST_ADD;
                  MODE_TICK:  state_in = ST_TICK;
                  MODE_CLEAR: state_in = ST_CLEAR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_last  = 1'b1;
               cmd.do_insert = !status.full;
               cmd.out_kind  = status.full ? KIND_DROPPED : KIND_ADDED;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = 1'b1;
               cmd.do_clear = 1'b1;
               cmd.out_kind = KIND_CLEARED;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.head_due) begin
                  cmd.do_pop   = 1'b1;
                  cmd.out_kind = KIND_FIRED;
                  cmd.out_last = !status.next_due;
                  if (!status.next_due) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.out_kind = KIND_NONE_DUE;
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TOEQ_ASSERT_IMPLY(a_no_overwrite, cmd.load_out, !rsp_valid_ff || rsp_ready,
                      "Result register overwritten while an item waits.")
   `TOEQ_ASSERT_IMPLY(a_insert_room, cmd.do_insert, !status.full,
                      "Insert issued into a full queue.")
   `TOEQ_ASSERT_IMPLY(a_pop_due, cmd.do_pop, status.head_due && state_ff == ST_TICK,
                      "Pop issued without a due head event.")

endmodule

`default_nettype wire

>>> rtl/time_ordered_event_queue_core.sv
// Time-ordered event queue.
// The req channel takes one item per handshake: mode add inserts the event
// (due_time, handler_id, payload) behind all stored events with an equal or
// earlier time, mode tick pops every event due at or before now, and mode
// clear empties the queue. An unused mode is taken and dropped without a result.
// The rsp channel returns one item per add (added or dropped full), one per
// clear, one nothing-due item for a tick with nothing due, or one fired item
// per due event; last marks the final item caused by each request.
// An item is taken in idle and its first result is registered from the add,
// clear or tick state once the result register is free; no new item is taken
// until the last result is registered. A tick holds req ready low and, while
// rsp ready allows, fires one event per cycle from the sorted cell chain head.
// The result register frees as the receiver takes an item; while rsp ready
// is low the block holds the pending result and waits before the next one.
// Synchronous reset empties the queue and drops any pending result; no
// clearing pass is needed, the block is ready as soon as reset is released.
`default_nettype none

module time_ordered_event_queue_core (
   input wire logic   clock,
   input wire logic   reset,
   toeq_req_if.sink   req_ch,
   toeq_rsp_if.source rsp_ch
);
   import toeq_pkg::*;

   cmd_type    cmd;
   status_type status;

   toeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_mode  (req_ch.mode),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   toeq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_due_time      (req_ch.due_time),
      .req_handler_id    (req_ch.handler_id),
      .req_payload       (req_ch.payload),
      .req_now           (req_ch.now),
      .rsp_kind          (rsp_ch.kind),
      .rsp_fired_handler (rsp_ch.fired_handler),
      .rsp_fired_payload (rsp_ch.fired_payload),
      .rsp_fired_time    (rsp_ch.fired_time),
      .rsp_last          (rsp_ch.last)
   );

endmodule

`default_nettype wire
